FILE: src/vpf_pkg.sv
// Package for the vertical/point/flick detector.
// Sizes, register indexes, controller states and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package vpf_pkg;

  localparam int MAX_HISTORY = 8;
  localparam int ZONE_BITS   = 4;
  localparam int TIME_W      = 32;
  localparam int SECS_W      = 8;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = $clog2(MAX_HISTORY + 1);
  localparam int IDX_W       = $clog2(MAX_HISTORY);
  localparam int EL_W        = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int YC_W        = ((ZONE_BITS > CNT_W) ? ZONE_BITS : CNT_W) + 1;
  localparam int IN_BITS     = 2 * ZONE_BITS + TIME_W;
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = SECS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HISTORY_LEN = 2'd0,
    REG_VERT_WIN    = 2'd1,
    REG_POINT_HOLD  = 2'd2,
    REG_FLICK_WIN   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_UPDATE = 2'd1,
    ST_CHECK  = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic check;
  } dp_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

FILE: src/vpf_ctrl.sv
// Controller for the detector: sequences capture, history update and flag check.
// Depends on vpf_pkg.
`timescale 1ns / 1ps

module vpf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  vpf_pkg::dp_status_t status,
  output vpf_pkg::dp_cmd_t    cmd
);

  vpf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      vpf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = vpf_pkg::ST_UPDATE;
        end
      end
      vpf_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = vpf_pkg::ST_CHECK;
      end
      vpf_pkg::ST_CHECK: begin
        if (!status.out_stall) begin
          cmd.check = 1'b1;
          state_nxt = vpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vpf_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/vpf_datapath.sv
// Datapath: configuration registers, zone history shift line, gesture checks
// and the output register. Depends on vpf_pkg.
`timescale 1ns / 1ps

module vpf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [vpf_pkg::IN_W-1:0]          in_tdata,
  input  vpf_pkg::dp_cmd_t                  cmd,
  output vpf_pkg::dp_status_t               status,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vpf_pkg::OUT_W-1:0]         out_tdata
);

  localparam int ZB = vpf_pkg::ZONE_BITS;
  localparam int TW = vpf_pkg::TIME_W;
  localparam int MH = vpf_pkg::MAX_HISTORY;

  logic [vpf_pkg::LEN_W-1:0]  hist_len_r;
  logic [vpf_pkg::SECS_W-1:0] vert_win_r, point_hold_r, flick_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r   <= vpf_pkg::LEN_W'(5);
      vert_win_r   <= vpf_pkg::SECS_W'(3);
      point_hold_r <= vpf_pkg::SECS_W'(3);
      flick_win_r  <= vpf_pkg::SECS_W'(2);
    end else if (cfg_we) begin
      unique case (vpf_pkg::cfg_reg_t'(cfg_index))
        vpf_pkg::REG_HISTORY_LEN: hist_len_r   <= cfg_wdata[vpf_pkg::LEN_W-1:0];
        vpf_pkg::REG_VERT_WIN:    vert_win_r   <= cfg_wdata;
        vpf_pkg::REG_POINT_HOLD:  point_hold_r <= cfg_wdata;
        vpf_pkg::REG_FLICK_WIN:   flick_win_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  logic [ZB-1:0] zx_r, zy_r;
  logic [TW-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      zx_r  <= in_tdata[ZB-1:0];
      zy_r  <= in_tdata[2*ZB-1:ZB];
      now_r <= in_tdata[2*ZB+TW-1:2*ZB];
    end
  end

  // history, newest at index 0
  logic [ZB-1:0] hx_r [MH];
  logic [ZB-1:0] hy_r [MH];
  logic [TW-1:0] hs_r [MH];
  logic [TW-1:0] he_r [MH];
  logic [vpf_pkg::CNT_W-1:0] count_r;

  logic [vpf_pkg::CNT_W-1:0] eff_len;
  always_comb begin
    if (hist_len_r == '0) begin
      eff_len = vpf_pkg::CNT_W'(1);
    end else if (vpf_pkg::EL_W'(hist_len_r) > vpf_pkg::EL_W'(MH)) begin
      eff_len = vpf_pkg::CNT_W'(MH);
    end else begin
      eff_len = vpf_pkg::CNT_W'(hist_len_r);
    end
  end

  logic none_seen, same_zone, grow;
  assign none_seen = (zx_r == '0) && (zy_r == '0);
  assign same_zone = (zx_r == hx_r[0]) && (zy_r == hy_r[0]);
  assign grow      = (count_r < eff_len) && (count_r < vpf_pkg::CNT_W'(MH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= vpf_pkg::CNT_W'(1);
      for (int i = 0; i < MH; i++) begin
        hx_r[i] <= '0;
        hy_r[i] <= '0;
        hs_r[i] <= '0;
        he_r[i] <= '0;
      end
    end else if (cmd.update && !none_seen) begin
      if (same_zone) begin
        he_r[0] <= now_r;
      end else begin
        for (int i = 1; i < MH; i++) begin
          hx_r[i] <= hx_r[i-1];
          hy_r[i] <= hy_r[i-1];
          hs_r[i] <= hs_r[i-1];
          he_r[i] <= he_r[i-1];
        end
        hx_r[0] <= zx_r;
        hy_r[0] <= zy_r;
        hs_r[0] <= now_r;
        he_r[0] <= now_r;
        if (grow) count_r <= count_r + vpf_pkg::CNT_W'(1);
      end
    end
  end

  // gesture checks
  logic [vpf_pkg::CNT_W-1:0] last_cnt;
  logic [TW-1:0]             vert_span, point_span, flick_span;
  logic                      full, rows_ok, vert_ok, point_ok, flick_ok;

  assign last_cnt   = count_r - vpf_pkg::CNT_W'(1);
  assign full       = (count_r == eff_len);
  assign vert_span  = he_r[0] - he_r[last_cnt[vpf_pkg::IDX_W-1:0]];
  assign point_span = he_r[0] - hs_r[0];
  assign flick_span = he_r[0] - he_r[2];

  always_comb begin
    rows_ok = 1'b1;
    for (int j = 0; j < MH; j++) begin
      if (vpf_pkg::CNT_W'(j) < count_r) begin
        if (vpf_pkg::YC_W'(hy_r[j]) != (vpf_pkg::YC_W'(count_r) - vpf_pkg::YC_W'(j)))
          rows_ok = 1'b0;
        if (hx_r[j] != hx_r[0]) rows_ok = 1'b0;
      end
    end
  end

  assign vert_ok  = full && rows_ok && (vert_span < TW'(vert_win_r));
  assign point_ok = (point_span >= TW'(point_hold_r));
  assign flick_ok = full && (count_r >= vpf_pkg::CNT_W'(3))
                    && (flick_span < TW'(flick_win_r))
                    && (hx_r[2] == hx_r[0]) && (hy_r[2] == hy_r[0])
                    && (hx_r[1] == hx_r[2])
                    && ((vpf_pkg::YC_W'(hy_r[1]) + vpf_pkg::YC_W'(1)) == vpf_pkg::YC_W'(hy_r[2]));

  // output register
  logic       out_valid_r;
  logic [2:0] flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.check) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) flags_r <= {flick_ok, point_ok, vert_ok};
  end

  assign status.out_stall = out_valid_r && !out_tready;
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = {(vpf_pkg::OUT_W - 3)'(0), flags_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= vpf_pkg::CNT_W'(1)) && (count_r <= vpf_pkg::CNT_W'(MH)))
    else $error("history count out of range");

  a_count_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.update |=> $stable(count_r))
    else $error("history count moved outside an update");

  a_out_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.check))
    else $error("result raised without a check");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.check |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while stalled");

endmodule

FILE: src/vertical_point_flick_detector.sv
// Top level of the vertical/point/flick gesture detector.
// Joins vpf_ctrl and vpf_datapath; depends on vpf_pkg.
//
// Usage:
//   in_*  : one item per camera frame. in_tdata = zone_x [3:0], zone_y [7:4],
//           now_secs [39:8]. Zone (0,0) leaves the history unchanged.
//   out_* : one result per item. out_tdata = vertical_seen [0], point_seen [1],
//           flick_seen [2], zeros above.
//   cfg_* : write port, index 0 history_len, 1 vertical window, 2 point hold,
//           3 flick window. The user writes only while idle; not enforced.
// Sequence: the controller takes an item in the idle state, updates the history
//   in the update state and checks and registers the flags in the check state,
//   which waits while the output register holds a stalled result; out_tvalid
//   rises as the flags are registered. No new item is taken until the check.
// Reset: history holds a single entry at zone (0,0) with times 0, registers
//   take their reset values, no result is pending.
// Stall: a result waits in the output register; the next item is accepted
//   and updated meanwhile, and the check waits until the register frees.
`timescale 1ns / 1ps

module vertical_point_flick_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vpf_pkg::IN_W-1:0]       in_tdata,   // zone_x, zone_y, now_secs
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [vpf_pkg::OUT_W-1:0]      out_tdata,  // vertical, point, flick, pad
  input  logic                           cfg_we,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  vpf_pkg::dp_cmd_t    cmd;
  vpf_pkg::dp_status_t status;

  vpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vpf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: verif/vertical_point_flick_detector_tb.sv
// Self-checking bench for vertical_point_flick_detector: directed zone items, then
// gesture-shaped random streams under several pacing and register settings.
// Depends on vpf_pkg and the detector RTL only.
`timescale 1ns / 1ps

module vertical_point_flick_detector_tb;

  typedef struct packed {
    logic flick;
    logic point;
    logic vertical;
  } gesture_t;

  typedef struct packed {
    logic [3:0]  zx;
    logic [3:0]  zy;
    logic [31:0] secs;
    logic        typed;
    gesture_t    flags;  // flick, point, vertical from the top bit down
  } probe_t;

  typedef enum int {PACE_FULL, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} pace_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [vpf_pkg::IN_W-1:0]       in_tdata   = '0;  // zone_x, zone_y, now_secs
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [vpf_pkg::OUT_W-1:0]      out_tdata;        // vertical, point, flick, pad
  logic                           cfg_we     = 1'b0;
  logic [vpf_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [vpf_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // shadow of the block's history and registers
  logic [3:0]  hist_x     [vpf_pkg::MAX_HISTORY];
  logic [3:0]  hist_y     [vpf_pkg::MAX_HISTORY];
  logic [31:0] hist_start [vpf_pkg::MAX_HISTORY];
  logic [31:0] hist_end   [vpf_pkg::MAX_HISTORY];
  int unsigned hist_count;
  logic [3:0]  set_len;
  logic [7:0]  vert_win, hold_secs, flick_win;

  gesture_t    pending_gestures[$];
  int unsigned failures    = 0;
  int unsigned zones_sent  = 0;
  int unsigned rx_hold_req = 0;
  logic [31:0] clock_secs  = '0;
  pace_t       pace        = PACE_FULL;

  probe_t probes [21] = '{
    '{4'd0,  4'd0,  32'd0,          1'b1, 3'b000},
    '{4'd0,  4'd0,  32'h1234_5678,  1'b1, 3'b000},
    '{4'd15, 4'd15, 32'hFFFF_FFFF,  1'b1, 3'b000},
    '{4'd15, 4'd15, 32'd2,          1'b1, 3'b010},
    '{4'd15, 4'd0,  32'd3,          1'b0, 3'b000},
    '{4'd3,  4'd1,  32'd10,         1'b0, 3'b000},
    '{4'd3,  4'd2,  32'd10,         1'b0, 3'b000},
    '{4'd3,  4'd3,  32'd11,         1'b0, 3'b000},
    '{4'd3,  4'd4,  32'd11,         1'b0, 3'b000},
    '{4'd3,  4'd5,  32'd12,         1'b0, 3'b000},
    '{4'd3,  4'd5,  32'd13,         1'b0, 3'b000},
    '{4'd3,  4'd4,  32'd13,         1'b0, 3'b000},
    '{4'd3,  4'd5,  32'd13,         1'b0, 3'b000},
    '{4'd3,  4'd5,  32'd14,         1'b0, 3'b000},
    '{4'd3,  4'd5,  32'd15,         1'b0, 3'b000},
    '{4'd3,  4'd5,  32'd16,         1'b0, 3'b000},
    '{4'd0,  4'd0,  32'd100,        1'b0, 3'b000},
    '{4'd0,  4'd15, 32'd17,         1'b0, 3'b000},
    '{4'd15, 4'd0,  32'd17,         1'b0, 3'b000},
    '{4'd8,  4'd8,  32'h8000_0000,  1'b0, 3'b000},
    '{4'd7,  4'd7,  32'h7FFF_FFFF,  1'b0, 3'b000}
  };

  vertical_point_flick_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("vertical_point_flick_detector verification failed");
    $finish;
  end

  function automatic int unsigned active_len();
    if (set_len == 4'd0) return 1;
    if (set_len > vpf_pkg::MAX_HISTORY) return vpf_pkg::MAX_HISTORY;
    return 32'(set_len);
  endfunction

  function automatic gesture_t track_zone(logic [3:0] zx, logic [3:0] zy, logic [31:0] t);
    gesture_t    g;
    int unsigned n, a, b, c;
    logic [31:0] span;
    if (zx == 4'd0 && zy == 4'd0) begin
      // nothing seen
    end else if (zx == hist_x[hist_count-1] && zy == hist_y[hist_count-1]) begin
      hist_end[hist_count-1] = t;
    end else begin
      if (hist_count + 1 > active_len() || hist_count >= vpf_pkg::MAX_HISTORY) begin
        for (int i = 0; i + 1 < hist_count; i++) begin
          hist_x[i]     = hist_x[i+1];
          hist_y[i]     = hist_y[i+1];
          hist_start[i] = hist_start[i+1];
          hist_end[i]   = hist_end[i+1];
        end
        hist_count--;
      end
      hist_x[hist_count]     = zx;
      hist_y[hist_count]     = zy;
      hist_start[hist_count] = t;
      hist_end[hist_count]   = t;
      hist_count++;
    end
    n = hist_count;

    span = hist_end[n-1] - hist_end[0];
    g.vertical = (n == active_len()) && (hist_y[0] == 4'd1) && (span < vert_win);
    for (int i = 1; i < n; i++)
      if (int'(hist_y[i]) != i + 1 || hist_x[i] != hist_x[0]) g.vertical = 1'b0;

    span = hist_end[n-1] - hist_start[n-1];
    g.point = (span >= hold_secs);

    g.flick = 1'b0;
    if (n == active_len() && n >= 3) begin
      a = n - 3;
      b = n - 2;
      c = n - 1;
      span = hist_end[c] - hist_end[a];
      g.flick = (span < flick_win) && hist_x[a] == hist_x[c] && hist_y[a] == hist_y[c]
                && int'(hist_y[b]) + 1 == int'(hist_y[a]) && hist_x[b] == hist_x[a];
    end
    return g;
  endfunction

  function automatic bit tx_idles();
    case (pace)
      PACE_TX_IDLE: return $urandom_range(0, 99) < 73;
      PACE_BOTH:    return $urandom_range(0, 99) < 27;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit rx_stalls();
    case (pace)
      PACE_RX_STALL: return $urandom_range(0, 99) < 73;
      PACE_BOTH:     return $urandom_range(0, 99) < 27;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] advance_secs(int unsigned max_step);
    clock_secs += $urandom_range(0, max_step);
    return clock_secs;
  endfunction

  task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
    failures++;
    if (failures <= 10) $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic offer_zone(input logic [3:0] zx, input logic [3:0] zy, input logic [31:0] t,
                            input logic typed = 1'b0, input gesture_t typed_flags = '0);
    gesture_t g;
    while (tx_idles()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, zy, zx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = track_zone(zx, zy, t);
    pending_gestures.insert(pending_gestures.size(), typed ? typed_flags : g);
    if (zx != 4'd0 || zy != 4'd0) zones_sent++;
  endtask

  task automatic await_results();
    in_tvalid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(vpf_pkg::cfg_reg_t idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      vpf_pkg::REG_HISTORY_LEN: set_len   = val[3:0];
      vpf_pkg::REG_VERT_WIN:    vert_win  = val;
      vpf_pkg::REG_POINT_HOLD:  hold_secs = val;
      vpf_pkg::REG_FLICK_WIN:   flick_win = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [3:0] len, logic [7:0] vw, logic [7:0] ph,
                                logic [7:0] fw);
    write_reg(vpf_pkg::REG_HISTORY_LEN, {4'd0, len});
    write_reg(vpf_pkg::REG_VERT_WIN, vw);
    write_reg(vpf_pkg::REG_POINT_HOLD, ph);
    write_reg(vpf_pkg::REG_FLICK_WIN, fw);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_window();
    case ($urandom_range(0, 6))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic run_gestures(int unsigned quota);
    int unsigned first, n;
    logic [3:0]  x, y;
    first = zones_sent;
    while (zones_sent - first < quota) begin
      x = 4'($urandom_range(0, 15));
      y = 4'($urandom_range(1, 15));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, vpf_pkg::MAX_HISTORY)
                                           : active_len();
          for (int i = 1; i <= n; i++) begin
            offer_zone(x, 4'(i), advance_secs(1));
            if ($urandom_range(0, 5) == 0) offer_zone(x, 4'(i), advance_secs(1));
          end
        end
        3, 4: begin
          offer_zone(x, y, advance_secs(1));
          offer_zone(x, y - 4'd1, advance_secs(1));
          offer_zone(x, y, advance_secs(1));
          if ($urandom_range(0, 2) == 0) offer_zone(x, y, advance_secs(1));
        end
        5: begin
          n = $urandom_range(2, 5);
          repeat (n) offer_zone(x, y, advance_secs(2));
        end
        6: begin
          // sweep spoilt by a stray row or column
          n = active_len();
          for (int i = 1; i <= n; i++) begin
            if ($urandom_range(0, 3) == 0)
              offer_zone(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), advance_secs(1));
            else
              offer_zone(x, 4'(i), advance_secs(1));
          end
        end
        7: offer_zone(x, 4'($urandom_range(0, 15)), advance_secs(4));
        8: begin
          if ($urandom_range(0, 1) == 0) clock_secs = $urandom();
          else clock_secs = 32'hFFFF_FFFF - $urandom_range(0, 4);
          offer_zone(x, y, clock_secs);
        end
        default: offer_zone(4'd0, 4'd0, $urandom());
      endcase
    end
  endtask

  initial begin : receiver
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        out_tready <= !rx_stalls();
      end
    end
  end

  always @(posedge clk) begin : check_results
    gesture_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_gestures.size() == 0) begin
        note_failure("result with none pending", 32'd0, 32'(out_tdata));
      end else begin
        want = pending_gestures[0];
        pending_gestures.delete(0);
        if (out_tdata[0] !== want.vertical)
          note_failure("vertical_seen", 32'(want.vertical), 32'(out_tdata[0]));
        if (out_tdata[1] !== want.point)
          note_failure("point_seen", 32'(want.point), 32'(out_tdata[1]));
        if (out_tdata[2] !== want.flick)
          note_failure("flick_seen", 32'(want.flick), 32'(out_tdata[2]));
      end
    end
  end

  initial begin : stimulus
    logic [3:0] len;
    for (int i = 0; i < vpf_pkg::MAX_HISTORY; i++) begin
      hist_x[i] = '0; hist_y[i] = '0; hist_start[i] = '0; hist_end[i] = '0;
    end
    hist_count = 1;
    set_len    = 4'd5;
    vert_win   = 8'd3;
    hold_secs  = 8'd3;
    flick_win  = 8'd2;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i])
      offer_zone(probes[i].zx, probes[i].zy, probes[i].secs, probes[i].typed, probes[i].flags);
    await_results();
    clock_secs = 32'd20;

    for (int ph = 0; zones_sent < 950; ph++) begin
      case (ph)
        0: apply_settings(4'd8, 8'd255, 8'd0, 8'd255);
        1: apply_settings(4'd3, 8'd0, 8'd255, 8'd0);    // shorter than the history held
        2: apply_settings(4'd0, 8'd3, 8'd3, 8'd2);
        3: apply_settings(4'd15, 8'd4, 8'd1, 8'd3);
        4: apply_settings(4'd1, 8'd2, 8'd2, 8'd2);
        5: apply_settings(4'd2, 8'd5, 8'd4, 8'd4);
        default: begin
          len = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(3, 8))
                                           : 4'($urandom_range(0, 15));
          apply_settings(len, pick_window(), pick_window(), pick_window());
        end
      endcase

      if (ph == 2) begin
        // long output hold-off with the input kept busy
        pace        = PACE_FULL;
        rx_hold_req = 60;
        run_gestures(12);
      end

      pace = pace_t'(ph % 4);
      run_gestures($urandom_range(50, 90));
      await_results();
    end

    repeat (10) @(posedge clk);
    if (pending_gestures.size() != 0)
      note_failure("results missing", 32'd0, 32'(pending_gestures.size()));
    if (failures == 0) begin
      $display("vertical_point_flick_detector verification clean");
    end else begin
      $display("vertical_point_flick_detector verification failed");
    end
    $finish;
  end

endmodule
